// File: rtl/ubs_pkg.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer package
// Field widths, register map, fixed constants and the structs that pass
// between the configuration block, the controller and the datapath.
// ----------------------------------------------------------------------------
package ubs_pkg;

  // Field and state widths
  localparam int COUNT_W  = 8;   // active_transfers field
  localparam int LIMIT_W  = 20;  // limit in KiB per second
  localparam int OBUF_W   = 21;  // socket output buffer size
  localparam int BUDGET_W = 30;  // budget, spent and slice_bytes
  localparam int SLICE_W  = 21;  // stored slice size
  localparam int CYCLE_W  = 7;   // send cycle period in ms
  localparam int DIV_W    = 31;  // shared divider operand width
  localparam int KIB_W    = 10;  // KiB to bytes shift

  // APB port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Constants of the budget rules
  localparam logic [OBUF_W-1:0]   OBUF_RESET    = OBUF_W'(65536);
  localparam logic [CYCLE_W-1:0]  CYCLE_FULL    = CYCLE_W'(100);
  localparam logic [BUDGET_W-1:0] EXHAUST_GRANT = BUDGET_W'(16);
  localparam int                  BUF_SCALE     = 1000;

  // Opcodes
  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_SLICE = 1'b1;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_THROTTLE_ON = 2'd0,
    REG_LIMIT       = 2'd1,
    REG_OUT_BUFFER  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                throttle_on;
    logic [LIMIT_W-1:0]  limit_kib_per_sec;
    logic [OBUF_W-1:0]   out_buffer_bytes;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;       // latch the incoming transaction
    logic setup_load;    // load budget and enable, form buffer products
    logic setup_cmp;     // compare budget against ten times buffer by count
    logic div_start;     // launch the shared divider
    logic setup_commit;  // store slice size and cycle time, clear spent
    logic req_left;      // form the remaining budget
    logic req_grant;     // choose the grant
    logic finish;        // load the result register and charge spent
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic active;
    logic div_done;
  } ctrl_sts_t;

endpackage

// File: rtl/ubs_req_if.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer request channel
// Valid/ready channel carrying one setup or slice request.
// ----------------------------------------------------------------------------
interface ubs_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [ubs_pkg::COUNT_W-1:0] active_transfers;

  modport source (output valid, output opcode, output active_transfers, input ready);
  modport sink   (input valid, input opcode, input active_transfers, output ready);
endinterface

// File: rtl/ubs_res_if.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface ubs_res_if;
  logic                         valid;
  logic                         ready;
  logic [ubs_pkg::BUDGET_W-1:0] slice_bytes;
  logic                         unlimited;
  logic                         budget_exhausted;
  logic [ubs_pkg::CYCLE_W-1:0]  cycle_time_ms;
  logic                         throttling_active;

  modport source (output valid, output slice_bytes, output unlimited,
                  output budget_exhausted, output cycle_time_ms,
                  output throttling_active, input ready);
  modport sink   (input valid, input slice_bytes, input unlimited,
                  input budget_exhausted, input cycle_time_ms,
                  input throttling_active, output ready);
endinterface

// File: rtl/upload_bandwidth_slicer.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer
// Splits a per-second upload budget into send slices for running transfers.
// ----------------------------------------------------------------------------
// Usage:
//   request  : valid/ready channel. opcode 0 is a setup for a new period
//              carrying active_transfers, opcode 1 asks for a send slice.
//   result   : valid/ready channel, exactly one result per request, in order.
//   APB port : throttle_on at 0x0, limit_kib_per_sec at 0x4, out_buffer_bytes
//              at 0x8; write only while no request is in flight.
// A slice request passes LEFT, GRANT and FINISH; a setup passes LOAD,
// COMPARE and, when active, DIV_START, DIV_WAIT and COMMIT before FINISH.
// The active setup waits on the shared restoring divider, which resolves one
// quotient bit per cycle over 31 bits. One request is worked on at a time.
// The result sits in an output register, so the next request is accepted
// while an earlier result waits; when the receiver stalls, the block finishes
// the request in hand and then holds until the result register is free.
// Reset clears throttling, budget, spent amount, slice size and cycle time,
// and sets the output buffer size to 65536 bytes.
// ----------------------------------------------------------------------------
module upload_bandwidth_slicer #(
  parameter int MAX_TRANSFERS = 255
) (
  input  logic                        clk,
  input  logic                        rst,
  ubs_req_if.sink                     request,
  ubs_res_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ubs_pkg::ADDR_W-1:0]  paddr,
  input  logic [ubs_pkg::DATA_W-1:0]  pwdata,
  output logic [ubs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ubs_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ubs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ubs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (request.valid),
    .req_opcode (request.opcode),
    .req_ready  (request.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ubs_datapath #(
    .MAX_TRANSFERS (MAX_TRANSFERS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cmd               (cmd),
    .sts               (sts),
    .opcode            (request.opcode),
    .active_transfers  (request.active_transfers),
    .slice_bytes       (result.slice_bytes),
    .unlimited         (result.unlimited),
    .budget_exhausted  (result.budget_exhausted),
    .cycle_time_ms     (result.cycle_time_ms),
    .throttling_active (result.throttling_active)
  );

endmodule

// File: rtl/ubs_cfg.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer configuration registers
// APB register file: throttle switch, limit and output buffer size.
// ----------------------------------------------------------------------------
module ubs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ubs_pkg::ADDR_W-1:0]  paddr,
  input  logic [ubs_pkg::DATA_W-1:0]  pwdata,
  output logic [ubs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ubs_pkg::cfg_t               cfg
);
  import ubs_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_on       <= 1'b0;
      cfg.limit_kib_per_sec <= '0;
      cfg.out_buffer_bytes  <= OBUF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_THROTTLE_ON: cfg.throttle_on       <= pwdata[0];
        REG_LIMIT:       cfg.limit_kib_per_sec <= pwdata[LIMIT_W-1:0];
        REG_OUT_BUFFER:  cfg.out_buffer_bytes  <= pwdata[OBUF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THROTTLE_ON: prdata = DATA_W'(cfg.throttle_on);
      REG_LIMIT:       prdata = DATA_W'(cfg.limit_kib_per_sec);
      REG_OUT_BUFFER:  prdata = DATA_W'(cfg.out_buffer_bytes);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: rtl/ubs_divider.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer divider
// Restoring divider, one quotient bit per cycle over W bits.
// ----------------------------------------------------------------------------
module ubs_divider #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);
  localparam int CW = $clog2(W);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted  = {rem, quo[W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      // keep the difference when the trial subtraction does not borrow
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: rtl/ubs_datapath.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer datapath
// Budget state, buffer products, shared divider, grant choice and result
// register, stepped by commands from the controller.
// ----------------------------------------------------------------------------
module ubs_datapath #(
  parameter int MAX_TRANSFERS = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ubs_pkg::cfg_t                 cfg,
  input  ubs_pkg::ctrl_cmd_t            cmd,
  output ubs_pkg::ctrl_sts_t            sts,
  input  logic                          opcode,
  input  logic [ubs_pkg::COUNT_W-1:0]   active_transfers,
  output logic [ubs_pkg::BUDGET_W-1:0]  slice_bytes,
  output logic                          unlimited,
  output logic                          budget_exhausted,
  output logic [ubs_pkg::CYCLE_W-1:0]   cycle_time_ms,
  output logic                          throttling_active
);
  import ubs_pkg::*;

  localparam int CNT_W  = (MAX_TRANSFERS < 255) ? $clog2(MAX_TRANSFERS + 1) : COUNT_W;
  localparam int PROD_W = OBUF_W + CNT_W;
  localparam int TEN_W  = PROD_W + 4;
  localparam int CMP_W  = (TEN_W > BUDGET_W) ? TEN_W : BUDGET_W;
  localparam int FIVE_W = CNT_W + 3;
  localparam logic [16:0] MAX_N = 17'(MAX_TRANSFERS);

  // item and budget state
  logic                 op_q;
  logic [CNT_W-1:0]     n_q;
  logic                 active_flag;
  logic [BUDGET_W-1:0]  budget_bytes;
  logic [BUDGET_W-1:0]  spent_bytes;
  logic [SLICE_W-1:0]   slice_size;
  logic [CYCLE_W-1:0]   cycle_ms;

  // working registers
  logic [PROD_W-1:0]    prod;
  logic [DIV_W-1:0]     buf_k;
  logic                 small_budget;
  logic [BUDGET_W-1:0]  left;
  logic [BUDGET_W-1:0]  grant;
  logic                 unlim_q;
  logic                 exh_q;

  logic [CNT_W-1:0]     n_sat;
  logic [CMP_W-1:0]     ten_prod;
  logic [FIVE_W-1:0]    five_n;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_divisor;
  logic [DIV_W-1:0]     div_quo;
  logic                 div_done;

  assign n_sat = ({9'd0, active_transfers} > MAX_N) ? MAX_N[CNT_W-1:0]
                                                    : active_transfers[CNT_W-1:0];
  assign ten_prod = (CMP_W'(prod) << 3) + (CMP_W'(prod) << 1);
  assign five_n   = (FIVE_W'(n_q) << 2) + FIVE_W'(n_q);

  assign div_dividend = small_budget ? DIV_W'(budget_bytes) : buf_k;
  assign div_divisor  = small_budget ? DIV_W'(five_n) : DIV_W'(budget_bytes);

  ubs_divider #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign sts.active   = active_flag;
  assign sts.div_done = div_done;

  // budget state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag  <= 1'b0;
      budget_bytes <= '0;
      spent_bytes  <= '0;
      slice_size   <= '0;
      cycle_ms     <= '0;
    end else begin
      if (cmd.setup_load) begin
        budget_bytes <= {cfg.limit_kib_per_sec, KIB_W'(0)};
        active_flag  <= cfg.throttle_on && (cfg.limit_kib_per_sec != '0) && (n_q != '0);
      end
      if (cmd.setup_commit) begin
        if (small_budget) begin
          slice_size <= (div_quo > DIV_W'(cfg.out_buffer_bytes)) ? cfg.out_buffer_bytes
                                                                 : div_quo[SLICE_W-1:0];
          cycle_ms   <= CYCLE_FULL;
        end else begin
          slice_size <= cfg.out_buffer_bytes;
          cycle_ms   <= div_quo[CYCLE_W-1:0];
        end
        spent_bytes <= '0;
      end
      // charge the grant once the result is handed over
      if (cmd.finish && op_q == OP_SLICE && active_flag && !exh_q) begin
        spent_bytes <= spent_bytes + grant;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= opcode;
      n_q     <= n_sat;
      grant   <= '0;
      unlim_q <= 1'b0;
      exh_q   <= 1'b0;
    end
    if (cmd.setup_load) begin
      prod  <= PROD_W'(cfg.out_buffer_bytes) * PROD_W'(n_q);
      buf_k <= DIV_W'(cfg.out_buffer_bytes) * DIV_W'(BUF_SCALE);
    end
    if (cmd.setup_cmp) begin
      small_budget <= CMP_W'(budget_bytes) <= ten_prod;
    end
    if (cmd.req_left) begin
      unlim_q <= !active_flag;
      left    <= (budget_bytes > spent_bytes) ? budget_bytes - spent_bytes : '0;
    end
    if (cmd.req_grant && active_flag) begin
      if (left != '0) begin
        grant <= ({1'b0, left} > {9'd0, slice_size, 1'b0}) ? BUDGET_W'(slice_size) : left;
        exh_q <= 1'b0;
      end else begin
        grant <= EXHAUST_GRANT;
        exh_q <= 1'b1;
      end
    end
    if (cmd.finish) begin
      slice_bytes       <= grant;
      unlimited         <= unlim_q;
      budget_exhausted  <= exh_q;
      cycle_time_ms     <= cycle_ms;
      throttling_active <= active_flag;
    end
  end

endmodule

// File: rtl/ubs_ctrl.sv
// ----------------------------------------------------------------------------
// Upload bandwidth slicer controller
// Sequences setup and slice requests through the datapath and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module ubs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_opcode,
  output logic                 req_ready,
  output logic                 res_valid,
  input  logic                 res_ready,
  output ubs_pkg::ctrl_cmd_t   cmd,
  input  ubs_pkg::ctrl_sts_t   sts
);
  import ubs_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_LOAD      = 9'b000000010,
    S_COMPARE   = 9'b000000100,
    S_DIV_START = 9'b000001000,
    S_DIV_WAIT  = 9'b000010000,
    S_COMMIT    = 9'b000100000,
    S_LEFT      = 9'b001000000,
    S_GRANT     = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = (req_opcode == OP_SETUP) ? S_LOAD : S_LEFT;
        end
      end
      S_LOAD: begin
        cmd.setup_load = 1'b1;
        state_next     = S_COMPARE;
      end
      S_COMPARE: begin
        // enable is settled now; an inactive setup leaves the rest alone
        cmd.setup_cmp = 1'b1;
        state_next    = sts.active ? S_DIV_START : S_FINISH;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.setup_commit = 1'b1;
        state_next       = S_FINISH;
      end
      S_LEFT: begin
        cmd.req_left = 1'b1;
        state_next   = S_GRANT;
      end
      S_GRANT: begin
        cmd.req_grant = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!res_valid || res_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule
